>>> rtl/olkfe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// olkfe_pkg: shared definitions for the ordered list core
// Field widths, operation codes and status codes used by the list core.
// ----------------------------------------------------------------------------
package olkfe_pkg;

  localparam int MAX_ENTRIES_DEFAULT = 64;

  localparam int OPCODE_W   = 2;
  localparam int VALUE_W    = 32;
  localparam int POSITION_W = 7;
  localparam int STATUS_W   = 2;
  localparam int HELD_W     = 7;

  localparam logic [OPCODE_W-1:0] OP_APPEND = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_DELETE = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_QUERY  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BADPOS   = 2'd3;

endpackage
`default_nettype wire

>>> rtl/ordered_list_kth_from_end_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ordered_list_kth_from_end_core: bounded ordered list with k-th-from-end read
// Appends values at the tail, deletes the first equal value and closes the
// gap, and reads the k-th value counted from the tail.
// ----------------------------------------------------------------------------
//
//   channel   ports                                        handshake
//   -------   -------------------------------------------  ---------------------
//   command   opcode, value, position_from_end             start high, busy low
//   result    read_value, status, entries_held             done high, one cycle
//
// Append, the unused opcode and a query with a bad position give their result
// the cycle after the command and never raise busy. A query in range holds
// busy while the one RAM read completes in S_QUERY and registers its answer.
// A delete scans the list through the single RAM read port, one entry per
// cycle, and moves later entries down in the same pass: it holds busy until
// no read is in flight and none is left to issue, then registers its answer.
// Reset clears the state, the entry count, the scan flags and done; the store
// needs no clearing. The receiver cannot stall results.
//
module ordered_list_kth_from_end_core #(
  parameter int MAX_ENTRIES = olkfe_pkg::MAX_ENTRIES_DEFAULT
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                start,
  output      logic                                busy,
  input  wire logic [olkfe_pkg::OPCODE_W-1:0]      opcode,
  input  wire logic signed [olkfe_pkg::VALUE_W-1:0] value,
  input  wire logic [olkfe_pkg::POSITION_W-1:0]    position_from_end,
  output      logic                                done,
  output      logic signed [olkfe_pkg::VALUE_W-1:0] read_value,
  output      logic [olkfe_pkg::STATUS_W-1:0]      status,
  output      logic [olkfe_pkg::HELD_W-1:0]        entries_held
);

  import olkfe_pkg::*;

  localparam int AW   = $clog2(MAX_ENTRIES);
  localparam int CW   = $clog2(MAX_ENTRIES + 1);
  localparam int CMPW = (CW > POSITION_W) ? CW : POSITION_W;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SCAN  = 3'b010,
    S_QUERY = 3'b100
  } state_t;

  state_t               state;
  logic [CW-1:0]        entry_count;
  logic [CW-1:0]        rd_idx;
  logic [AW-1:0]        data_idx;
  logic                 pend;
  logic                 found;
  logic [VALUE_W-1:0]   del_value;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [VALUE_W-1:0]   ram_wdata;
  logic [AW-1:0]        ram_raddr;
  logic [VALUE_W-1:0]   ram_rdata;

  logic                 full;
  logic                 issue;
  logic                 match;
  logic [CMPW-1:0]      k_ext;
  logic [CMPW-1:0]      cnt_ext;
  logic [CMPW-1:0]      q_diff;
  logic                 q_bad;

  assign busy    = (state != S_IDLE);
  assign full    = (entry_count == CW'(MAX_ENTRIES));
  assign issue   = (rd_idx < entry_count);
  assign match   = (ram_rdata == del_value);
  assign k_ext   = CMPW'(position_from_end);
  assign cnt_ext = CMPW'(entry_count);
  assign q_diff  = cnt_ext - k_ext;
  assign q_bad   = (k_ext == '0) || (k_ext > cnt_ext);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = entry_count[AW-1:0];
    ram_wdata = value;
    ram_raddr = q_diff[AW-1:0];
    if (state == S_IDLE && start && opcode == OP_APPEND && !full) begin
      ram_we = 1'b1;
    end
    if (state == S_SCAN) begin
      ram_raddr = rd_idx[AW-1:0];
      // Once the match has passed, every later word moves down one place.
      if (pend && found) begin
        ram_we    = 1'b1;
        ram_waddr = data_idx - AW'(1);
        ram_wdata = ram_rdata;
      end
    end
  end

  olkfe_ram #(
    .WIDTH(VALUE_W),
    .DEPTH(MAX_ENTRIES)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      entry_count <= '0;
      rd_idx      <= '0;
      pend        <= 1'b0;
      found       <= 1'b0;
      done        <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            read_value <= '0;
            unique case (opcode)
              OP_APPEND: begin
                done <= 1'b1;
                if (full) begin
                  status       <= ST_FULL;
                  entries_held <= HELD_W'(entry_count);
                end else begin
                  status       <= ST_OK;
                  entry_count  <= entry_count + CW'(1);
                  entries_held <= HELD_W'(entry_count + CW'(1));
                end
              end
              OP_DELETE: begin
                state     <= S_SCAN;
                rd_idx    <= '0;
                pend      <= 1'b0;
                found     <= 1'b0;
                del_value <= value;
              end
              OP_QUERY: begin
                if (q_bad) begin
                  done         <= 1'b1;
                  status       <= ST_BADPOS;
                  entries_held <= HELD_W'(entry_count);
                end else begin
                  state <= S_QUERY;
                end
              end
              default: begin
                done         <= 1'b1;
                status       <= ST_OK;
                entries_held <= HELD_W'(entry_count);
              end
            endcase
          end
        end
        S_SCAN: begin
          rd_idx   <= rd_idx + CW'(issue);
          pend     <= issue;
          data_idx <= rd_idx[AW-1:0];
          if (pend && !found && match) begin
            found <= 1'b1;
          end
          // The pass ends when no read is in flight and none is left to issue.
          if (!pend && !issue) begin
            state      <= S_IDLE;
            done       <= 1'b1;
            read_value <= '0;
            if (found) begin
              status       <= ST_OK;
              entry_count  <= entry_count - CW'(1);
              entries_held <= HELD_W'(entry_count - CW'(1));
            end else begin
              status       <= ST_NOTFOUND;
              entries_held <= HELD_W'(entry_count);
            end
          end
        end
        S_QUERY: begin
          state        <= S_IDLE;
          done         <= 1'b1;
          read_value   <= ram_rdata;
          status       <= ST_OK;
          entries_held <= HELD_W'(entry_count);
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

>>> rtl/olkfe_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// olkfe_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module olkfe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire
